// ----- hw/rtl/spc_pkg.sv -----
// Shared widths and stage payload types for the sphere/plane collision pipeline.
// No dependencies; imported by every spc_* module and the top level.
package spc_pkg;

    localparam int POS_W  = 32;   // Q16.16 positions
    localparam int RAD_W  = 31;   // unsigned Q15.16 radius
    localparam int QUAT_W = 16;   // Q1.14 quaternion parts
    localparam int NRM_W  = 16;   // Q1.14 normal parts
    localparam int DIF_W  = 33;   // exact centre difference
    localparam int PRD_W  = 32;   // quaternion part products
    localparam int V_W    = 34;   // rotated up vector, signed
    localparam int ABS_W  = 32;   // |v| before scaling
    localparam int MAG_W  = 30;   // |v| after scaling, max in [2^29, 2^30)
    localparam int SQ_W   = 60;
    localparam int SUM_W  = 62;
    localparam int LEN_W  = 31;   // floor(sqrt(sum))
    localparam int REM_W  = 64;   // sqrt remainder
    localparam int DEN_W  = 32;   // 2 * len
    localparam int Q_W    = 15;   // normal magnitude, at most 16384
    localparam int NUM_W  = 47;   // divider remainder
    localparam int PP_W   = 49;   // difference times normal
    localparam int PS_W   = 51;   // sum of three products
    localparam int PM_W   = 50;
    localparam int PJ_W   = 37;   // rounded projection before saturation
    localparam int IN_W   = 288;
    localparam int OUT_W  = 56;
    localparam int MSB_TARGET = 29;

    typedef struct packed {
        logic signed [POS_W-1:0]  sx;
        logic signed [POS_W-1:0]  sy;
        logic signed [POS_W-1:0]  sz;
        logic        [RAD_W-1:0]  r;
        logic signed [POS_W-1:0]  px;
        logic signed [POS_W-1:0]  py;
        logic signed [POS_W-1:0]  pz;
        logic signed [QUAT_W-1:0] qw;
        logic signed [QUAT_W-1:0] qx;
        logic signed [QUAT_W-1:0] qy;
        logic signed [QUAT_W-1:0] qz;
    } t_pair;

    // data that rides along with the normal computation
    typedef struct packed {
        logic signed [DIF_W-1:0] dx;
        logic signed [DIF_W-1:0] dy;
        logic signed [DIF_W-1:0] dz;
        logic        [RAD_W-1:0] r;
        logic        [2:0]       neg;   // sign of v, index 0 is x
        logic                    zero;  // v is exactly zero
    } t_side;

    typedef logic [2:0][MAG_W-1:0] t_mag;
    typedef logic [2:0][NRM_W-1:0] t_nrm;

endpackage

// ----- hw/rtl/spc_vec.sv -----
// Up vector rotation by the plane quaternion, magnitude scaling and sum of squares.
// Seven register stages; uses spc_pkg.
module spc_vec (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  spc_pkg::t_pair              i_pair,
    output logic                        o_vld,
    output spc_pkg::t_side              o_side,
    output spc_pkg::t_mag               o_mag,
    output logic [spc_pkg::SUM_W-1:0]   o_sum
);
    import spc_pkg::*;

    logic [6:0] r_vld;

    // stage 1: products and differences
    logic signed [PRD_W-1:0] r_pxy, r_pwz, r_pxx, r_pzz, r_pyz, r_pwx;
    t_side r_s1;
    // stage 2: v
    logic signed [V_W-1:0] r_v [3];
    t_side r_s2;
    // stage 3: magnitudes
    logic [2:0][ABS_W-1:0] r_a3;
    t_side r_s3;
    // stage 4: leading one
    logic [2:0][ABS_W-1:0] r_a4;
    logic                  r_shr;
    logic [4:0]            r_sh;
    t_side r_s4;
    // stage 5..7
    t_mag r_a5, r_a6, r_a7;
    logic [2:0][SQ_W-1:0] r_sq;
    logic [SUM_W-1:0]     r_sum;
    t_side r_s5, r_s6, r_s7;

    logic [ABS_W-1:0] w_or;
    logic [4:0]       w_lead;

    always_comb begin
        w_or   = r_a3[0] | r_a3[1] | r_a3[2];
        w_lead = '0;
        for (int i = 0; i < ABS_W; i++) begin
            if (w_or[i]) begin
                w_lead = 5'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[5:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pxy <= i_pair.qx * i_pair.qy;
            r_pwz <= i_pair.qw * i_pair.qz;
            r_pxx <= i_pair.qx * i_pair.qx;
            r_pzz <= i_pair.qz * i_pair.qz;
            r_pyz <= i_pair.qy * i_pair.qz;
            r_pwx <= i_pair.qw * i_pair.qx;
            r_s1.dx   <= DIF_W'(i_pair.sx) - DIF_W'(i_pair.px);
            r_s1.dy   <= DIF_W'(i_pair.sy) - DIF_W'(i_pair.py);
            r_s1.dz   <= DIF_W'(i_pair.sz) - DIF_W'(i_pair.pz);
            r_s1.r    <= i_pair.r;
            r_s1.neg  <= '0;
            r_s1.zero <= 1'b0;

            r_v[0] <= (V_W'(r_pxy) - V_W'(r_pwz)) <<< 1;
            r_v[1] <= (V_W'(1) <<< 28) - ((V_W'(r_pxx) + V_W'(r_pzz)) <<< 1);
            r_v[2] <= (V_W'(r_pyz) + V_W'(r_pwx)) <<< 1;
            r_s2   <= r_s1;

            r_s3.dx   <= r_s2.dx;
            r_s3.dy   <= r_s2.dy;
            r_s3.dz   <= r_s2.dz;
            r_s3.r    <= r_s2.r;
            r_s3.zero <= r_s2.zero;
            for (int i = 0; i < 3; i++) begin
                r_a3[i]     <= r_v[i][V_W-1] ? ABS_W'(-r_v[i]) : ABS_W'(r_v[i]);
                r_s3.neg[i] <= r_v[i][V_W-1];
            end

            r_a4      <= r_a3;
            r_shr     <= (w_lead > 5'(MSB_TARGET));
            r_sh      <= (w_lead > 5'(MSB_TARGET)) ? w_lead - 5'(MSB_TARGET)
                                                   : 5'(MSB_TARGET) - w_lead;
            r_s4.dx   <= r_s3.dx;
            r_s4.dy   <= r_s3.dy;
            r_s4.dz   <= r_s3.dz;
            r_s4.r    <= r_s3.r;
            r_s4.neg  <= r_s3.neg;
            r_s4.zero <= (w_or == '0);

            for (int i = 0; i < 3; i++) begin
                r_a5[i] <= r_shr ? MAG_W'(r_a4[i] >> r_sh) : MAG_W'(r_a4[i] << r_sh);
            end
            r_s5 <= r_s4;

            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= SQ_W'(r_a5[i]) * SQ_W'(r_a5[i]);
            end
            r_a6 <= r_a5;
            r_s6 <= r_s5;

            r_sum <= SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
            r_a7  <= r_a6;
            r_s7  <= r_s6;
        end
    end

    assign o_vld  = r_vld[6];
    assign o_side = r_s7;
    assign o_mag  = r_a7;
    assign o_sum  = r_sum;

endmodule

// ----- hw/rtl/spc_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
// LEN_W register stages; uses spc_pkg.
module spc_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  spc_pkg::t_side              i_side,
    input  spc_pkg::t_mag               i_mag,
    input  logic [spc_pkg::SUM_W-1:0]   i_sum,
    output logic                        o_vld,
    output spc_pkg::t_side              o_side,
    output spc_pkg::t_mag               o_mag,
    output logic [spc_pkg::LEN_W-1:0]   o_len
);
    import spc_pkg::*;

    localparam int STG = LEN_W;

    logic [STG-1:0]   r_vld;
    logic [REM_W-1:0] r_rem  [STG];
    logic [LEN_W-1:0] r_root [STG];
    t_side            r_side [STG];
    t_mag             r_mag  [STG];

    for (genvar j = 0; j < STG; j++) begin : g_stg
        localparam int K = STG - 1 - j;
        logic [REM_W-1:0] w_rem;
        logic [REM_W-1:0] w_trial;
        logic [LEN_W-1:0] w_root;
        logic             w_vld;
        t_side            w_side;
        t_mag             w_mag;

        if (j == 0) begin : g_first
            assign w_rem  = REM_W'(i_sum);
            assign w_root = '0;
            assign w_vld  = i_vld;
            assign w_side = i_side;
            assign w_mag  = i_mag;
        end else begin : g_next
            assign w_rem  = r_rem[j-1];
            assign w_root = r_root[j-1];
            assign w_vld  = r_vld[j-1];
            assign w_side = r_side[j-1];
            assign w_mag  = r_mag[j-1];
        end

        // (root + 2^K)^2 - root^2
        assign w_trial = (REM_W'(w_root) << (K + 1)) + (REM_W'(1) << (2 * K));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_rem >= w_trial) begin
                    r_rem[j]  <= w_rem - w_trial;
                    r_root[j] <= w_root | (LEN_W'(1) << K);
                end else begin
                    r_rem[j]  <= w_rem;
                    r_root[j] <= w_root;
                end
                r_side[j] <= w_side;
                r_mag[j]  <= w_mag;
            end
        end
    end

    assign o_vld  = r_vld[STG-1];
    assign o_side = r_side[STG-1];
    assign o_mag  = r_mag[STG-1];
    assign o_len  = r_root[STG-1];

endmodule

// ----- hw/rtl/spc_norm.sv -----
// Three-lane pipelined restoring divider: normal = round(|v| * 2^14 / len), signed.
// Q_W + 2 register stages; uses spc_pkg.
module spc_norm (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  spc_pkg::t_side              i_side,
    input  spc_pkg::t_mag               i_mag,
    input  logic [spc_pkg::LEN_W-1:0]   i_len,
    output logic                        o_vld,
    output spc_pkg::t_side              o_side,
    output spc_pkg::t_nrm               o_nrm
);
    import spc_pkg::*;

    localparam int STG = Q_W + 1;   // prep stage plus one per quotient bit

    logic [STG-1:0]        r_vld;
    logic [2:0][NUM_W-1:0] r_rem  [STG];
    logic [2:0][Q_W-1:0]   r_q    [STG];
    logic [DEN_W-1:0]      r_den  [STG];
    t_side                 r_side [STG];

    logic  r_vld_o;
    t_side r_side_o;
    t_nrm  r_nrm;

    // prep: numerator a*2^15 + len, divisor 2*len
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_rem[0][i] <= (NUM_W'(i_mag[i]) << Q_W) + NUM_W'(i_len);
                r_q[0][i]   <= '0;
            end
            r_den[0]  <= {i_len, 1'b0};
            r_side[0] <= i_side;
        end
    end

    for (genvar j = 1; j < STG; j++) begin : g_stg
        localparam int K = STG - 1 - j;
        logic [NUM_W-1:0] w_dsh;

        assign w_dsh = NUM_W'(r_den[j-1]) << K;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= r_vld[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int i = 0; i < 3; i++) begin
                    if (r_rem[j-1][i] >= w_dsh) begin
                        r_rem[j][i] <= r_rem[j-1][i] - w_dsh;
                        r_q[j][i]   <= r_q[j-1][i] | (Q_W'(1) << K);
                    end else begin
                        r_rem[j][i] <= r_rem[j-1][i];
                        r_q[j][i]   <= r_q[j-1][i];
                    end
                end
                r_den[j]  <= r_den[j-1];
                r_side[j] <= r_side[j-1];
            end
        end
    end

    // apply the sign of v
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_o <= 1'b0;
        end else if (i_en) begin
            r_vld_o <= r_vld[STG-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_nrm[i] <= r_side[STG-1].neg[i] ? -NRM_W'(r_q[STG-1][i])
                                                 : NRM_W'(r_q[STG-1][i]);
            end
            r_side_o <= r_side[STG-1];
        end
    end

    assign o_vld  = r_vld_o;
    assign o_side = r_side_o;
    assign o_nrm  = r_nrm;

endmodule

// ----- hw/rtl/spc_proj.sv -----
// Projection of the centre difference onto the normal, rounding, saturation, compare.
// Four register stages, the last one is the output register; uses spc_pkg.
module spc_proj (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  spc_pkg::t_side    i_side,
    input  spc_pkg::t_nrm     i_nrm,
    output logic              o_vld,
    output logic              o_coll,
    output spc_pkg::t_nrm     o_nrm
);
    import spc_pkg::*;

    logic [3:0] r_vld;

    logic signed [PP_W-1:0] r_p [3];
    logic signed [PS_W-1:0] r_s;
    logic        [PM_W-1:0] r_pm;
    t_nrm                   r_nrm1, r_nrm2, r_nrm3;
    logic [RAD_W-1:0]       r_r1, r_r2, r_r3;
    logic                   r_z1, r_z2, r_z3;
    logic                   r_coll;
    t_nrm                   r_nrm_o;

    logic signed [DIF_W-1:0] w_d [3];
    logic [PS_W-1:0]         w_rnd;
    logic [PJ_W-1:0]         w_pj;
    logic [RAD_W-1:0]        w_sat;

    assign w_d[0] = i_side.dx;
    assign w_d[1] = i_side.dy;
    assign w_d[2] = i_side.dz;

    assign w_rnd = PS_W'(r_pm) + (PS_W'(1) << 13);
    assign w_pj  = w_rnd[PJ_W+13:14];
    assign w_sat = (w_pj[PJ_W-1:RAD_W] != '0) ? {RAD_W{1'b1}} : w_pj[RAD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_p[i] <= PP_W'(w_d[i]) * PP_W'($signed(i_nrm[i]));
            end
            r_nrm1 <= i_nrm;
            r_r1   <= i_side.r;
            r_z1   <= i_side.zero;

            r_s    <= PS_W'(r_p[0]) + PS_W'(r_p[1]) + PS_W'(r_p[2]);
            r_nrm2 <= r_nrm1;
            r_r2   <= r_r1;
            r_z2   <= r_z1;

            r_pm   <= r_s[PS_W-1] ? PM_W'(-r_s) : PM_W'(r_s);
            r_nrm3 <= r_nrm2;
            r_r3   <= r_r2;
            r_z3   <= r_z2;

            if (!r_z3 && (w_sat < r_r3)) begin
                r_coll  <= 1'b1;
                r_nrm_o <= r_nrm3;
            end else begin
                r_coll  <= 1'b0;
                r_nrm_o <= '0;
            end
        end
    end

    assign o_vld  = r_vld[3];
    assign o_coll = r_coll;
    assign o_nrm  = r_nrm_o;

endmodule

// ----- hw/rtl/sphere_plane_collision_test.sv -----
// Sphere/plane collision test, top level; uses spc_pkg, spc_vec, spc_sqrt, spc_norm, spc_proj.
// Path from request accept to result valid: vector, square root, divide, projection.
// Throughput: one pair per cycle while the output is not stalled; the 31-stage square root
// and the 15-step dividers are fully pipelined, one bit per stage.
// Backpressure freezes the whole pipe at once; nothing is dropped or repeated.
// Reset (i_rst_n, synchronous, active low) clears the valid bits only; no clearing pass.
module sphere_plane_collision_test (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // [31:0] sphere_pos_x, [63:32] sphere_pos_y, [95:64] sphere_pos_z,
    // [126:96] sphere_radius, [158:127] plane_pos_x, [190:159] plane_pos_y,
    // [222:191] plane_pos_z, [238:223] plane_quat_w, [254:239] plane_quat_x,
    // [270:255] plane_quat_y, [286:271] plane_quat_z, [287] zero
    input  logic [spc_pkg::IN_W-1:0]    s_axis_tdata,
    // result
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [0] colliding, [16:1] normal_x, [32:17] normal_y, [48:33] normal_z, [55:49] zero
    output logic [spc_pkg::OUT_W-1:0]   m_axis_tdata
);
    import spc_pkg::*;

    // one enable for every stage: advance unless the output register holds
    // a result that is not being taken
    logic  w_en;
    t_pair w_pair;

    logic  w_vec_vld, w_sqrt_vld, w_norm_vld, w_out_vld;
    t_side w_vec_side, w_sqrt_side, w_norm_side;
    t_mag  w_vec_mag, w_sqrt_mag;
    logic [SUM_W-1:0] w_sum;
    logic [LEN_W-1:0] w_len;
    t_nrm  w_nrm, w_out_nrm;
    logic  w_coll;

    assign w_en          = !w_out_vld || m_axis_tready;
    assign s_axis_tready = w_en;

    assign w_pair.sx = s_axis_tdata[31:0];
    assign w_pair.sy = s_axis_tdata[63:32];
    assign w_pair.sz = s_axis_tdata[95:64];
    assign w_pair.r  = s_axis_tdata[126:96];
    assign w_pair.px = s_axis_tdata[158:127];
    assign w_pair.py = s_axis_tdata[190:159];
    assign w_pair.pz = s_axis_tdata[222:191];
    assign w_pair.qw = s_axis_tdata[238:223];
    assign w_pair.qx = s_axis_tdata[254:239];
    assign w_pair.qy = s_axis_tdata[270:255];
    assign w_pair.qz = s_axis_tdata[286:271];

    // rotate the up vector, scale so the largest part sits at bit 29, square and sum
    spc_vec u_vec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (s_axis_tvalid),
        .i_pair  (w_pair),
        .o_vld   (w_vec_vld),
        .o_side  (w_vec_side),
        .o_mag   (w_vec_mag),
        .o_sum   (w_sum)
    );

    // vector length, floor of the root
    spc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_vec_vld),
        .i_side  (w_vec_side),
        .i_mag   (w_vec_mag),
        .i_sum   (w_sum),
        .o_vld   (w_sqrt_vld),
        .o_side  (w_sqrt_side),
        .o_mag   (w_sqrt_mag),
        .o_len   (w_len)
    );

    // unit normal in Q1.14, rounded half away from zero
    spc_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_sqrt_vld),
        .i_side  (w_sqrt_side),
        .i_mag   (w_sqrt_mag),
        .i_len   (w_len),
        .o_vld   (w_norm_vld),
        .o_side  (w_norm_side),
        .o_nrm   (w_nrm)
    );

    // distance along the normal against the radius; a zero vector never collides
    spc_proj u_proj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_norm_vld),
        .i_side  (w_norm_side),
        .i_nrm   (w_nrm),
        .o_vld   (w_out_vld),
        .o_coll  (w_coll),
        .o_nrm   (w_out_nrm)
    );

    assign m_axis_tvalid = w_out_vld;
    assign m_axis_tdata  = {7'b0, w_out_nrm[2], w_out_nrm[1], w_out_nrm[0], w_coll};

endmodule

// ----- tb/sphere_plane_collision_test_tb.sv -----
// Self-checking testbench for sphere_plane_collision_test: directed and random pairs,
// predicted in place and compared field by field. Depends on spc_pkg and the top level.
`timescale 1ns / 1ps

module sphere_plane_collision_test_tb;
    import spc_pkg::*;

    typedef struct packed {
        logic                     colliding;
        logic signed [NRM_W-1:0]  nx;
        logic signed [NRM_W-1:0]  ny;
        logic signed [NRM_W-1:0]  nz;
    } t_contact;

    typedef struct {
        logic signed [POS_W-1:0]  sx, sy, sz;
        logic        [RAD_W-1:0]  r;
        logic signed [POS_W-1:0]  px, py, pz;
        logic signed [QUAT_W-1:0] qw, qx, qy, qz;
    } t_req;

    localparam int LATENCY   = 59;
    localparam int WDOG_MAX  = 2000;
    localparam int N_RANDOM  = 1800;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata;   // see DUT port list for field layout
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_W-1:0]      m_axis_tdata;   // [0] colliding, then normal x, y, z

    t_req       pending_reqs[$];
    t_contact   expected_contacts[$];
    int         n_errors = 0;
    bit         stim_done = 0;
    bit         drain_pause = 0;   // sender waits until every result is back
    int         hold_off = 0;      // receiver long stall, cycles left
    int         send_gap = 0;
    int         recv_gap = 0;
    int         idle_cycles = 0;
    int         n_sent = 0;

    sphere_plane_collision_test i_dut (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void add_req(t_req q);
        pending_reqs.insert(pending_reqs.size(), q);
    endfunction

    function automatic void add_exp(t_contact c);
        expected_contacts.insert(expected_contacts.size(), c);
    endfunction

    function automatic logic [IN_W-1:0] pack_req(t_req q);
        return {1'b0, q.qz, q.qy, q.qx, q.qw, q.pz, q.py, q.px, q.r, q.sz, q.sy, q.sx};
    endfunction

    // floor(sqrt(n)), bit by bit
    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Contact predictor: plane normal from the quaternion, then absolute distance test.
    function automatic t_contact predict_contact(t_req q);
        t_contact c;
        longint d[3], v[3], nn[3], w, x, y, z, p;
        logic [63:0] a[3], mx, sum, len, pos, neg, pm, proj, qv;
        c = '0;
        d[0] = longint'(q.sx) - longint'(q.px);
        d[1] = longint'(q.sy) - longint'(q.py);
        d[2] = longint'(q.sz) - longint'(q.pz);
        w = q.qw; x = q.qx; y = q.qy; z = q.qz;
        v[0] = 2 * (x * y - w * z);
        v[1] = (longint'(1) << 28) - 2 * (x * x + z * z);
        v[2] = 2 * (y * z + w * x);
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            a[i] = v[i] < 0 ? -v[i] : v[i];
            if (a[i] > mx) mx = a[i];
        end
        if (mx == 0) return c;   // degenerate quaternion: no normal, no contact
        while (mx >= (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) a[i] = a[i] >> 1;
            mx = mx >> 1;
        end
        while (mx < (64'd1 << 29)) begin
            for (int i = 0; i < 3; i++) a[i] = a[i] << 1;
            mx = mx << 1;
        end
        sum = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            qv = (a[i] * 64'd32768 + len) / (2 * len);
            nn[i] = v[i] < 0 ? -longint'(qv) : longint'(qv);
        end
        pos = 0; neg = 0;
        for (int i = 0; i < 3; i++) begin
            p = d[i] * nn[i];
            if (p < 0) neg += -p;
            else pos += p;
        end
        pm = pos >= neg ? pos - neg : neg - pos;
        proj = (pm + 64'd8192) >> 14;
        if (proj > 64'h7FFF_FFFF) proj = 64'h7FFF_FFFF;
        if (proj < {33'd0, q.r}) begin
            c.colliding = 1'b1;
            c.nx = nn[0][15:0];
            c.ny = nn[1][15:0];
            c.nz = nn[2][15:0];
        end
        return c;
    endfunction

    function automatic logic [31:0] rand_pos(bit near);
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: return near ? $urandom_range(0, 32'h0008_0000) - 32'h0004_0000
                                 : $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_quat();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return $urandom;
            default: return $urandom_range(0, 32768) - 16384;   // mostly near-unit range
        endcase
    endfunction

    function automatic t_req rand_req();
        t_req q;
        bit near;
        near = $urandom_range(0, 3) != 0;
        q.sx = rand_pos(near); q.sy = rand_pos(near); q.sz = rand_pos(near);
        q.px = rand_pos(near); q.py = rand_pos(near); q.pz = rand_pos(near);
        case ($urandom_range(0, 4))
            0: q.r = 31'h7FFF_FFFF;
            1: q.r = 0;
            2: q.r = $urandom;
            default: q.r = $urandom_range(0, 32'h0004_0000);
        endcase
        q.qw = rand_quat(); q.qx = rand_quat(); q.qy = rand_quat(); q.qz = rand_quat();
        return q;
    endfunction

    function automatic t_req mk_req(logic [31:0] s, logic [30:0] r, logic [31:0] p,
                                    logic [15:0] w, logic [15:0] x, logic [15:0] y,
                                    logic [15:0] z);
        t_req q;
        q.sx = s; q.sy = s; q.sz = s; q.r = r;
        q.px = p; q.py = p; q.pz = p;
        q.qw = w; q.qx = x; q.qy = y; q.qz = z;
        return q;
    endfunction

    // Stimulus: directed corners, then random pairs.
    initial begin
        t_req q;
        // identity quaternion, just inside / exactly on radius / just inside on the negative side
        q = mk_req(32'h0, 31'h10000, 32'h0, 16'h4000, 0, 0, 0);
        q.sy = 32'h0000_FFFF; add_req(q);
        q.sy = 32'h0001_0000; add_req(q);
        q.sy = -32'sh0000_FFFF; add_req(q);
        // near-degenerate quaternion: x=z=0 and w,y chosen so v is zero is impossible
        // with v_y = 2^28; zero v needs x^2+z^2 = 2^27 with cross terms zero
        add_req(mk_req(32'h0, 31'h7FFF_FFFF, 32'h0, 0, 16'h2D41, 16'h0, 0));
        add_req(mk_req(0, 31'h7FFF_FFFF, 0, 16'h2000, 16'h2000, 16'h2000, 16'h2000));
        // extreme positions, saturating projection
        add_req(mk_req(32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h8000_0000,
                       16'h4000, 0, 0, 0));
        add_req(mk_req(32'h8000_0000, 31'h7FFF_FFFF, 32'h7FFF_FFFF,
                       16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        add_req(mk_req(32'hFFFF_FFFF, 31'h0, 32'h0,
                       16'h8000, 16'h8000, 16'h8000, 16'h8000));
        add_req(mk_req(0, 31'h1, 0, 16'h8000, 16'h7FFF, 0, 16'h8000));
        add_req(mk_req(32'h0001_0000, 31'h7FFF_FFFF, 0, 0, 16'h4000, 0, 0));
        add_req(mk_req(32'h0001_0000, 31'h7FFF_FFFF, 0, 0, 0, 0, 16'h4000));
        add_req(mk_req(32'h5555_5555, 31'h2AAA_AAAA, 32'hAAAA_AAAA,
                       16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
        for (int i = 0; i < N_RANDOM; i++) add_req(rand_req());
    end

    // Driver: one request per handshake, random gap before each.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            send_gap      <= 0;
        end else if (s_axis_tvalid && !s_axis_tready) begin
            // hold the request until accepted
        end else begin
            if (s_axis_tvalid) begin
                add_exp(predict_contact(pending_reqs.pop_front()));
                n_sent <= n_sent + 1;
                send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
                if (n_sent == 900) drain_pause <= 1'b1;
            end
            if (s_axis_tvalid) begin
                // next request either goes at once or waits for its gap
                if ($urandom_range(0, 2) == 0 && pending_reqs.size() > 0 && !drain_pause
                    && n_sent != 900) begin
                    s_axis_tdata  <= pack_req(pending_reqs[0]);
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end else if (drain_pause) begin
                if (expected_contacts.size() == 0) drain_pause <= 1'b0;
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (pending_reqs.size() > 0) begin
                s_axis_tdata  <= pack_req(pending_reqs[0]);
                s_axis_tvalid <= 1'b1;
            end else begin
                stim_done <= 1'b1;
            end
        end
    end

    // Monitor: random ready, one long hold-off to fill the pipe.
    always @(posedge i_clk) begin
        t_contact got, exp_c;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_gap      <= 0;
            hold_off      <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[0], m_axis_tdata[16:1], m_axis_tdata[32:17],
                       m_axis_tdata[48:33]};
                if (expected_contacts.size() == 0) begin
                    $error("result with nothing expected: %h", got);
                    n_errors++;
                end else begin
                    exp_c = expected_contacts.pop_front();
                    if (got.colliding !== exp_c.colliding) begin
                        $error("colliding exp %0d got %0d", exp_c.colliding, got.colliding);
                        n_errors++;
                    end
                    if (got.nx !== exp_c.nx) begin
                        $error("normal_x exp %0d got %0d", exp_c.nx, got.nx);
                        n_errors++;
                    end
                    if (got.ny !== exp_c.ny) begin
                        $error("normal_y exp %0d got %0d", exp_c.ny, got.ny);
                        n_errors++;
                    end
                    if (got.nz !== exp_c.nz) begin
                        $error("normal_z exp %0d got %0d", exp_c.nz, got.nz);
                        n_errors++;
                    end
                end
            end
            if (n_sent >= 400 && hold_off == 0 && !m_axis_tready) begin
                hold_off <= 300;
            end
            if (hold_off > 1) begin
                hold_off      <= hold_off - 1;
                m_axis_tready <= 1'b0;
            end else if (m_axis_tvalid && m_axis_tready || !m_axis_tready && recv_gap == 0)
            begin
                if (m_axis_tvalid && m_axis_tready) begin
                    recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= 1'b1;
                end
                if (hold_off == 1) hold_off <= -1;   // long stall done, never again
            end else if (!m_axis_tready) begin
                recv_gap <= recv_gap - 1;
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            begin
                wait (stim_done && expected_contacts.size() == 0);
                repeat (LATENCY + 10) @(posedge i_clk);
            end
            begin
                wait (idle_cycles >= WDOG_MAX);
                $display("timeout");
                n_errors++;
            end
        join_any
        if (n_errors == 0 && expected_contacts.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// ----- files.f -----
hw/rtl/spc_pkg.sv
hw/rtl/spc_vec.sv
hw/rtl/spc_sqrt.sv
hw/rtl/spc_norm.sv
hw/rtl/spc_proj.sv
hw/rtl/sphere_plane_collision_test.sv
tb/sphere_plane_collision_test_tb.sv
